@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed: condition does not hold");

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/msgcks_pkg.sv @@
`default_nettype none

package msgcks_pkg;

    // Trailer geometry: "10=NNN" plus the closing separator.
    localparam int unsigned DelayDepth = 7;
    localparam int unsigned CountSat   = 8;

    // Byte codes.
    localparam logic [7:0] SEP_SOH   = 8'h01;
    localparam logic [7:0] SEP_PIPE  = 8'h7C;
    localparam logic [7:0] CHR_ONE   = 8'h31;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_EQUAL = 8'h3D;
    localparam logic [5:0] DIGIT_ZERO = 6'h30;

    // Result of one message, as handed from the accumulator to the top level.
    typedef struct packed {
        logic       check_ok;
        logic [7:0] checksum;
        logic       pipe_separator;
    } t_msg_result;

    // The three ASCII digits of a checksum.
    typedef struct packed {
        logic [5:0] hundreds;
        logic [5:0] tens;
        logic [5:0] ones;
    } t_digits;

    // Splits a byte into decimal digits. The tens digit uses a multiply by
    // 205 and a shift by 11, which is exact for values below 100.
    function automatic t_digits to_digits(input logic [7:0] cs);
        logic [1:0]  h;
        logic [7:0]  rem;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [3:0]  o;
        t_digits     d;
        if (cs >= 8'd200) begin
            h   = 2'd2;
            rem = cs - 8'd200;
        end else if (cs >= 8'd100) begin
            h   = 2'd1;
            rem = cs - 8'd100;
        end else begin
            h   = 2'd0;
            rem = cs;
        end
        prod = 15'(rem[6:0]) * 15'd205;
        t    = prod[14:11];
        o    = 4'(rem - 8'(t) * 8'd10);
        d.hundreds = DIGIT_ZERO + 6'(h);
        d.tens     = DIGIT_ZERO + 6'(t);
        d.ones     = DIGIT_ZERO + 6'(o);
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/msgcks_channels.sv @@
`default_nettype none

// Input channel: one message byte per item.
interface msgcks_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Output channel: one check result per message.
interface msgcks_out_if;
    logic       valid;
    logic       ready;
    logic       check_ok;
    logic [7:0] checksum;
    logic [5:0] digit_hundreds;
    logic [5:0] digit_tens;
    logic [5:0] digit_ones;
    logic       pipe_separator;

    modport source (output valid, output check_ok, output checksum, output digit_hundreds,
                    output digit_tens, output digit_ones, output pipe_separator,
                    input ready);
    modport sink   (input valid, input check_ok, input checksum, input digit_hundreds,
                    input digit_tens, input digit_ones, input pipe_separator,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/msgcks_accum.sv @@
`default_nettype none

// Per-message state: trailer delay line, running sum, length count and the
// separator guess. The result for a byte is formed from the updated state in
// the same cycle, and the state clears after a last byte.
module msgcks_accum (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_step,
    input  wire logic [7:0]               i_data_byte,
    input  wire logic                     i_last_byte,
    output msgcks_pkg::t_msg_result       o_result
);

    localparam int unsigned Depth = msgcks_pkg::DelayDepth;

    logic [7:0] r_delay [Depth];
    logic [7:0] n_delay [Depth];
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic [3:0] r_count;
    logic [3:0] n_count;
    logic       r_found;
    logic       n_found;
    logic       r_pipe;
    logic       n_pipe;

    logic       absorb;
    logic [7:0] oldest;
    logic [7:0] addend;
    logic [7:0] sep;
    logic       ok;

    // Shift the delay line and fold the byte leaving it into the sum.
    always_comb begin
        oldest  = r_delay[0];
        absorb  = (r_count >= 4'(Depth));
        n_found = r_found;
        n_pipe  = r_pipe;
        if (absorb && !r_found &&
            (oldest == msgcks_pkg::SEP_SOH || oldest == msgcks_pkg::SEP_PIPE)) begin
            n_found = 1'b1;
            n_pipe  = (oldest == msgcks_pkg::SEP_PIPE);
        end
        if (n_pipe && oldest == msgcks_pkg::SEP_PIPE) begin
            addend = msgcks_pkg::SEP_SOH;
        end else begin
            addend = oldest;
        end
        n_sum = absorb ? r_sum + addend : r_sum;
        for (int i = 0; i < Depth - 1; i++) begin
            n_delay[i] = r_delay[i + 1];
        end
        n_delay[Depth - 1] = i_data_byte;
        n_count = (r_count < 4'(msgcks_pkg::CountSat)) ? r_count + 4'd1 : r_count;
    end

    // Message check on the updated state.
    always_comb begin
        sep = n_pipe ? msgcks_pkg::SEP_PIPE : msgcks_pkg::SEP_SOH;
        ok  = (n_count >= 4'(msgcks_pkg::CountSat))
           && (n_delay[0] == msgcks_pkg::CHR_ONE)
           && (n_delay[1] == msgcks_pkg::CHR_ZERO)
           && (n_delay[2] == msgcks_pkg::CHR_EQUAL)
           && (n_delay[Depth - 1] == sep);
        o_result.check_ok       = ok;
        o_result.checksum       = ok ? n_sum : 8'd0;
        o_result.pipe_separator = n_pipe;
    end

    // State update; a last byte returns everything to the cleared state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            for (int i = 0; i < Depth; i++) begin
                r_delay[i] <= 8'd0;
            end
            r_sum   <= 8'd0;
            r_count <= 4'd0;
            r_found <= 1'b0;
            r_pipe  <= 1'b0;
        end else if (i_step) begin
            r_delay <= n_delay;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_found <= n_found;
            r_pipe  <= n_pipe;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fix_message_checksum_core.sv @@
`default_nettype none

// Channel   Modport  Payload                                   Role
// i_byte    sink     data_byte[7:0], last_byte                 message bytes in
// o_result  source   check_ok, checksum[7:0], digit_* [5:0],   one result per message
//                    pipe_separator
//
// One byte is taken per clock cycle; the state update is a single 8-bit add.
// A result appears in the output register in the cycle after its last byte is taken.
// Synchronous active-low reset clears the message state and the output valid.
// While a result waits on o_result.ready, further bytes are held off by
// i_byte.ready; a taken result frees the register in the same cycle.

module fix_message_checksum_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    msgcks_in_if.sink    i_byte,
    msgcks_out_if.source o_result
);

    msgcks_pkg::t_msg_result acc_result;
    msgcks_pkg::t_msg_result r_result;
    msgcks_pkg::t_digits     digits;
    logic                    r_valid;
    logic                    accept;

    assign i_byte.ready = !r_valid || o_result.ready;
    assign accept       = i_byte.valid && i_byte.ready;

    msgcks_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (accept),
        .i_data_byte (i_byte.data_byte),
        .i_last_byte (i_byte.last_byte),
        .o_result    (acc_result)
    );

    // Output register: loaded on a last byte, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept && i_byte.last_byte) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_byte.last_byte) begin
            r_result <= acc_result;
        end
    end

    // ASCII digits from the held checksum.
    assign digits = msgcks_pkg::to_digits(r_result.checksum);

    assign o_result.valid          = r_valid;
    assign o_result.check_ok       = r_result.check_ok;
    assign o_result.checksum       = r_result.checksum;
    assign o_result.pipe_separator = r_result.pipe_separator;
    assign o_result.digit_hundreds = digits.hundreds;
    assign o_result.digit_tens     = digits.tens;
    assign o_result.digit_ones     = digits.ones;

endmodule

`default_nettype wire

@@ rtl/msgcks_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the checksum core.
module msgcks_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_last,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_check_ok,
    input wire logic [7:0] i_checksum,
    input wire logic [5:0] i_digit_hundreds,
    input wire logic [5:0] i_digit_tens,
    input wire logic [5:0] i_digit_ones
);

    logic [9:0] digit_value;
    logic       in_take;
    logic       out_free;

    assign digit_value = 10'(i_digit_hundreds - 6'h30) * 10'd100
                       + 10'(i_digit_tens - 6'h30) * 10'd10
                       + 10'(i_digit_ones - 6'h30);

    // Handshake shorthands: a byte item is taken, or the result register can move.
    assign in_take  = i_in_valid && i_in_ready;
    assign out_free = !i_out_valid || i_out_ready;

    // A stalled result holds its checksum.
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, !out_free, i_out_valid && $stable(i_checksum))

    // A failed check reports a zero checksum.
    `ASSERT_IMPLIES(a_zero_on_fail, i_clk, i_rst_n, i_out_valid && !i_check_ok, i_checksum == 8'd0)

    // The digits spell the checksum.
    `ASSERT_IMPLIES(a_digits, i_clk, i_rst_n, i_out_valid, digit_value == 10'(i_checksum))

    // A taken last byte produces a result in the next cycle.
    `ASSERT_NEXT(a_result, i_clk, i_rst_n, in_take && i_in_last, i_out_valid)

    // A byte that is not last never produces a result on its own.
    `ASSERT_NEXT(a_no_result, i_clk, i_rst_n, in_take && !i_in_last && out_free, !i_out_valid)

endmodule

bind fix_message_checksum_core msgcks_checker u_msgcks_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_byte.valid),
    .i_in_ready       (i_byte.ready),
    .i_in_last        (i_byte.last_byte),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_check_ok       (o_result.check_ok),
    .i_checksum       (o_result.checksum),
    .i_digit_hundreds (o_result.digit_hundreds),
    .i_digit_tens     (o_result.digit_tens),
    .i_digit_ones     (o_result.digit_ones)
);

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    // One byte of the message stream as it waits to be driven.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_msg_byte;

    // The verdict the block is expected to give for one message.
    typedef struct {
        logic       check_ok;
        logic [7:0] checksum;
        logic [5:0] hundreds;
        logic [5:0] tens;
        logic [5:0] ones;
        logic       pipe_sep;
    } t_msg_verdict;

    localparam int StallLimit = 1000;
    localparam int CalmItems  = 120;

    logic i_clk;
    logic i_rst_n;

    msgcks_in_if  byte_if ();
    msgcks_out_if result_if ();

    fix_message_checksum_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .o_result (result_if)
    );

    t_msg_byte    byte_queue[$];
    t_msg_verdict verdict_queue[$];
    int           mismatch_count;
    int           stall_cycles;
    int           gap_left;
    int           hold_left;
    logic         byte_taken;

    // Our own copy of the checker state.
    logic [7:0] trail_line[msgcks_pkg::DelayDepth];
    logic [7:0] body_sum;
    logic [3:0] seen_count;
    logic       sep_known;
    logic       sep_pipe;

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic clear_checker();
        foreach (trail_line[i]) trail_line[i] = 8'h00;
        body_sum   = 8'h00;
        seen_count = 4'd0;
        sep_known  = 1'b0;
        sep_pipe   = 1'b0;
    endtask

    // Advances the checker state by one byte; on the last byte it queues the verdict.
    task automatic absorb_msg_byte(input logic [7:0] b, input logic last);
        logic [7:0]   oldest;
        logic [7:0]   sep;
        logic         ok;
        int           cs;
        t_msg_verdict v;
        if (seen_count >= 4'(msgcks_pkg::DelayDepth)) begin
            oldest = trail_line[0];
            if (!sep_known && (oldest == msgcks_pkg::SEP_SOH
                               || oldest == msgcks_pkg::SEP_PIPE)) begin
                sep_known = 1'b1;
                sep_pipe  = (oldest == msgcks_pkg::SEP_PIPE);
            end
            // A pipe separator is summed as if it were SOH.
            if (sep_pipe && oldest == msgcks_pkg::SEP_PIPE) oldest = msgcks_pkg::SEP_SOH;
            body_sum = body_sum + oldest;
        end
        for (int i = 0; i < msgcks_pkg::DelayDepth - 1; i++) trail_line[i] = trail_line[i + 1];
        trail_line[msgcks_pkg::DelayDepth - 1] = b;
        if (seen_count < 4'(msgcks_pkg::CountSat)) seen_count = seen_count + 4'd1;
        if (last) begin
            sep = sep_pipe ? msgcks_pkg::SEP_PIPE : msgcks_pkg::SEP_SOH;
            ok  = (seen_count >= 4'(msgcks_pkg::CountSat))
                  && trail_line[0] == msgcks_pkg::CHR_ONE
                  && trail_line[1] == msgcks_pkg::CHR_ZERO
                  && trail_line[2] == msgcks_pkg::CHR_EQUAL
                  && trail_line[msgcks_pkg::DelayDepth - 1] == sep;
            cs  = ok ? int'(body_sum) : 0;
            v.check_ok = ok;
            v.checksum = 8'(cs);
            v.hundreds = msgcks_pkg::DIGIT_ZERO + 6'(cs / 100);
            v.tens     = msgcks_pkg::DIGIT_ZERO + 6'((cs % 100) / 10);
            v.ones     = msgcks_pkg::DIGIT_ZERO + 6'(cs % 10);
            v.pipe_sep = sep_pipe;
            verdict_queue.insert(verdict_queue.size(), v);
            clear_checker();
        end
    endtask

    function automatic int check_field(string fname, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Stimulus building.
    task automatic push_byte(input logic [7:0] b, input logic last);
        t_msg_byte m;
        m.data = b;
        m.last = last;
        byte_queue.insert(byte_queue.size(), m);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    endtask

    task automatic push_digits();
        repeat (3) push_byte(msgcks_pkg::CHR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    // Tag=value fields, each closed by the separator, with some raw bytes mixed in.
    task automatic push_body(input logic [7:0] sep, input int nfields);
        logic [7:0] c;
        repeat (nfields) begin
            repeat ($urandom_range(1, 3))
                push_byte(msgcks_pkg::CHR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            push_byte(msgcks_pkg::CHR_EQUAL, 1'b0);
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 7) == 0) begin
                    c = 8'($urandom_range(0, 255));
                end else begin
                    c = 8'($urandom_range(8'h20, 8'h7E));
                    if (c == msgcks_pkg::SEP_PIPE) c = "A";
                end
                push_byte(c, 1'b0);
            end
            push_byte(sep, 1'b0);
        end
    endtask

    // Stimulus: directed messages first, then random well-formed and broken traffic.
    initial begin
        logic [7:0] sep;
        int         kind;
        int         start_size;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = 8'h00;
        byte_if.last_byte = 1'b0;
        result_if.ready   = 1'b0;
        i_rst_n           = 1'b0;
        mismatch_count    = 0;
        stall_cycles      = 0;
        gap_left          = 0;
        hold_left         = 0;
        byte_taken        = 1'b0;
        clear_checker();

        // A lone all-ones byte is a message far too short to pass.
        push_byte(8'hFF, 1'b1);
        // Shortest valid message, SOH separator.
        push_byte(msgcks_pkg::SEP_SOH, 1'b0);
        push_text("10=001");
        push_byte(msgcks_pkg::SEP_SOH, 1'b1);
        // Shortest valid message, pipe separator.
        push_byte(msgcks_pkg::SEP_PIPE, 1'b0);
        push_text("10=001");
        push_byte(msgcks_pkg::SEP_PIPE, 1'b1);
        // No separator in the body: SOH is assumed.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_text("10=127");
        push_byte(msgcks_pkg::SEP_SOH, 1'b1);

        start_size = byte_queue.size();
        while (byte_queue.size() - start_size < 850) begin
            kind = $urandom_range(0, 9);
            sep  = $urandom_range(0, 1) ? msgcks_pkg::SEP_PIPE : msgcks_pkg::SEP_SOH;
            if (kind <= 6) begin
                push_body(sep, $urandom_range(1, 4));
                push_text("10=");
                push_digits();
                push_byte(sep, 1'b1);
            end else if (kind == 7) begin
                // Broken trailer: a damaged tag or a wrong closing byte.
                push_body(sep, $urandom_range(1, 3));
                case ($urandom_range(0, 3))
                    0: push_text("x0=");
                    1: push_text("1x=");
                    2: push_text("10x");
                    default: push_text("10=");
                endcase
                push_digits();
                push_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : sep, 1'b1);
            end else if (kind == 8) begin
                // Short message of random bytes.
                repeat ($urandom_range(0, 7)) push_byte(8'($urandom_range(0, 255)), 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                // Noise with scattered last flags.
                repeat ($urandom_range(1, 10))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
        // Close any message left open by the noise.
        push_byte(8'($urandom_range(0, 255)), 1'b1);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (byte_queue.size() != 0 || byte_if.valid || verdict_queue.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Byte driver with random gaps, none near the end of the stream.
    always @(negedge i_clk) begin
        t_msg_byte m;
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
        end else if (!byte_if.valid || byte_taken) begin
            if (gap_left == 0 && byte_queue.size() > CalmItems && $urandom_range(0, 9) == 0)
                gap_left = $urandom_range(1, 12);
            if (gap_left != 0) begin
                gap_left--;
                byte_if.valid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
                m = byte_queue.pop_front();
                byte_if.valid     <= 1'b1;
                byte_if.data_byte <= m.data;
                byte_if.last_byte <= m.last;
            end else begin
                byte_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver with random stall bursts.
    always @(negedge i_clk) begin
        if (hold_left == 0 && byte_queue.size() > CalmItems && $urandom_range(0, 7) == 0)
            hold_left = $urandom_range(1, 12);
        if (hold_left != 0) begin
            hold_left--;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted byte, check every accepted result.
    always @(posedge i_clk) begin
        t_msg_verdict v;
        byte_taken <= byte_if.valid && byte_if.ready;
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready)
                absorb_msg_byte(byte_if.data_byte, byte_if.last_byte);
            if (result_if.valid && result_if.ready) begin
                if (verdict_queue.size() == 0) begin
                    $error("result with no message pending");
                    mismatch_count++;
                end else begin
                    v = verdict_queue.pop_front();
                    mismatch_count += check_field("check_ok", v.check_ok, result_if.check_ok);
                    mismatch_count += check_field("checksum", v.checksum, result_if.checksum);
                    mismatch_count += check_field("digit_hundreds", v.hundreds,
                                                  result_if.digit_hundreds);
                    mismatch_count += check_field("digit_tens", v.tens, result_if.digit_tens);
                    mismatch_count += check_field("digit_ones", v.ones, result_if.digit_ones);
                    mismatch_count += check_field("pipe_separator", v.pipe_sep,
                                                  result_if.pipe_separator);
                end
            end
        end
    end

    // Watchdog on cycles where neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_if.valid && byte_if.ready)
            || (result_if.valid && result_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

@@ fix_message_checksum_core.f @@
+incdir+rtl
rtl/msgcks_pkg.sv
rtl/msgcks_channels.sv
rtl/msgcks_accum.sv
rtl/fix_message_checksum_core.sv
rtl/msgcks_checker.sv
dv/tb_top.sv
